### src/sm3_pkg.sv
// Shared types, constants and bit functions for the SM3 compression unit.
package sm3_pkg;

   localparam int unsigned WORD_WIDTH     = 32;
   localparam int unsigned NUM_IV         = 8;
   localparam int unsigned IV_INDEX_WIDTH = $clog2(NUM_IV);
   localparam int unsigned CSR_ADDR_WIDTH = IV_INDEX_WIDTH + 2;
   localparam int unsigned WORDS_PER_BLK  = 16;
   localparam int unsigned POS_WIDTH      = $clog2(WORDS_PER_BLK);
   localparam int unsigned NUM_ROUNDS     = 64;
   localparam int unsigned ROUND_WIDTH    = $clog2(NUM_ROUNDS);

   typedef logic [WORD_WIDTH-1:0]            sm3_word_type;
   typedef logic [NUM_IV-1:0][WORD_WIDTH-1:0] sm3_cv_type;

   // Round constant for rounds 0..15, and the rounds 16..63 constant
   // already rotated left by 16 (the rotation that round 16 needs).
   localparam sm3_word_type T_LOW        = 32'h79CC4519;
   localparam sm3_word_type T_HIGH_ROT16 = 32'h9D8A7A87;

   localparam sm3_cv_type IV_RESET = {
      32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
      32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
   };

   localparam logic [POS_WIDTH-1:0]   LAST_POS        = POS_WIDTH'(WORDS_PER_BLK - 1);
   localparam logic [ROUND_WIDTH-1:0] LAST_EARLY_RND  = ROUND_WIDTH'(15);
   localparam logic [ROUND_WIDTH-1:0] LAST_ROUND      = ROUND_WIDTH'(NUM_ROUNDS - 1);

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_ROUND,
      ST_FINAL
   } sm3_ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_iv;      // reload chaining value from IV registers
      logic load_word;    // shift an accepted message word into the window
      logic init_work;    // copy chaining value into working registers
      logic do_round;     // run one compression round
      logic early_round;  // round index below 16
      logic t_switch;     // last early round: switch round constant
      logic finish;       // fold working state into chaining value, load output
   } sm3_cmd_type;

   function automatic sm3_word_type rotl(sm3_word_type x, int unsigned n);
      logic [2*WORD_WIDTH-1:0] d;
      d = {x, x} << n;
      return d[2*WORD_WIDTH-1:WORD_WIDTH];
   endfunction

   function automatic sm3_word_type perm0(sm3_word_type x);
      return x ^ rotl(x, 9) ^ rotl(x, 17);
   endfunction

   function automatic sm3_word_type perm1(sm3_word_type x);
      return x ^ rotl(x, 15) ^ rotl(x, 23);
   endfunction

endpackage

### src/sm3_req_if.sv
// Input channel: message words with a start-of-message flag.
interface sm3_req_if import sm3_pkg::*;
();
   logic         valid;
   logic         ready;
   sm3_word_type message_word;
   logic         start_message;

   modport source (output valid, output message_word, output start_message, input ready);
   modport sink   (input valid, input message_word, input start_message, output ready);
endinterface

### src/sm3_rsp_if.sv
// Result channel: the 256-bit chaining value after each block.
interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_bits_255_192;
   logic [63:0] digest_bits_191_128;
   logic [63:0] digest_bits_127_64;
   logic [63:0] digest_bits_63_0;

   modport source (output valid, output digest_bits_255_192, output digest_bits_191_128,
                   output digest_bits_127_64, output digest_bits_63_0, input ready);
   modport sink   (input valid, input digest_bits_255_192, input digest_bits_191_128,
                   input digest_bits_127_64, input digest_bits_63_0, output ready);
endinterface

### src/sm3_ctrl.sv
// Controller: word gathering, round sequencing and result handshake.
module sm3_ctrl import sm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_start,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sm3_cmd_type cmd
);

   sm3_ctrl_state_type       state_ff, state_in;
   logic [POS_WIDTH-1:0]     pos_ff, pos_in;
   logic [ROUND_WIDTH-1:0]   round_ff, round_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [POS_WIDTH-1:0]     pos_eff;
   logic                     accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         pos_ff       <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      accept       = 1'b0;
      pos_eff      = pos_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_ready     = 1'b1;
            accept        = req_valid;
            pos_eff       = req_start ? '0 : pos_ff;
            cmd.load_iv   = accept && req_start;
            cmd.load_word = accept;
            if (accept) begin
               pos_in = pos_eff + 1'b1;
               if (pos_eff == LAST_POS) begin
                  cmd.init_work = 1'b1;
                  round_in      = '0;
                  state_in      = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            cmd.do_round    = 1'b1;
            cmd.early_round = (round_ff <= LAST_EARLY_RND);
            cmd.t_switch    = (round_ff == LAST_EARLY_RND);
            round_in        = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### src/sm3_datapath.sv
// Datapath: message window, expansion, round logic, chaining value, output.
module sm3_datapath import sm3_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sm3_cmd_type  cmd,
   input  sm3_word_type message_word,
   input  sm3_cv_type   iv,
   output sm3_cv_type   digest
);

   sm3_word_type               win_ff [WORDS_PER_BLK];
   sm3_word_type               win_in [WORDS_PER_BLK];
   sm3_cv_type                 cv_ff, cv_in;
   sm3_cv_type                 work_ff, work_in;
   sm3_cv_type                 dig_ff;
   sm3_word_type               tj_ff, tj_in;
   sm3_word_type               w_next, a12, ss1, ss2, ff_val, gg_val, tt1, tt2;
   sm3_cv_type                 folded;

   // Expand: W[j+16] from the current 16-word window W[j..j+15].
   assign w_next = perm1(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 15))
                   ^ rotl(win_ff[3], 7) ^ win_ff[10];

   always_comb begin
      a12 = rotl(work_ff[0], 12);
      ss1 = rotl(a12 + work_ff[4] + tj_ff, 7);
      ss2 = ss1 ^ a12;
      if (cmd.early_round) begin
         ff_val = work_ff[0] ^ work_ff[1] ^ work_ff[2];
         gg_val = work_ff[4] ^ work_ff[5] ^ work_ff[6];
      end else begin
         ff_val = (work_ff[0] & work_ff[1]) | (work_ff[0] & work_ff[2])
                  | (work_ff[1] & work_ff[2]);
         gg_val = (work_ff[4] & work_ff[5]) | (~work_ff[4] & work_ff[6]);
      end
      tt1 = ff_val + work_ff[3] + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2 = gg_val + work_ff[7] + ss1 + win_ff[0];
   end

   assign folded = cv_ff ^ work_ff;

   always_comb begin
      for (int i = 0; i < WORDS_PER_BLK - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[WORDS_PER_BLK-1] = cmd.do_round ? w_next : message_word;

      work_in = work_ff;
      tj_in   = tj_ff;
      if (cmd.init_work) begin
         work_in = cv_ff;
         tj_in   = T_LOW;
      end else if (cmd.do_round) begin
         work_in[0] = tt1;
         work_in[1] = work_ff[0];
         work_in[2] = rotl(work_ff[1], 9);
         work_in[3] = work_ff[2];
         work_in[4] = perm0(tt2);
         work_in[5] = work_ff[4];
         work_in[6] = rotl(work_ff[5], 19);
         work_in[7] = work_ff[6];
         tj_in      = cmd.t_switch ? T_HIGH_ROT16 : rotl(tj_ff, 1);
      end

      cv_in = cv_ff;
      if (cmd.load_iv) begin
         cv_in = iv;
      end else if (cmd.finish) begin
         cv_in = folded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= IV_RESET;
      end else begin
         cv_ff <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word || cmd.do_round) begin
         win_ff <= win_in;
      end
      work_ff <= work_in;
      tj_ff   <= tj_in;
      if (cmd.finish) begin
         dig_ff <= folded;
      end
   end

   assign digest = dig_ff;

endmodule

### src/sm3_hash_compression_unit.sv
// Top level: SM3 compression unit with IV registers, controller and datapath.
// The result is registered: after the 16th word is taken the 64 rounds run, then the fold loads
// the output register. No new word is taken until the block is folded, and the fold waits while
// the previous result is not yet taken; the pace is set by the single round unit.
// Reset (synchronous, active high): IV registers and chaining value take the standard
// SM3 IV, word position goes to zero, no result is pending.
module sm3_hash_compression_unit import sm3_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   sm3_req_if.sink                   req_chan,
   sm3_rsp_if.source                 rsp_chan,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   sm3_cv_type                  iv_ff, iv_in;
   logic                        csr_write;
   logic [IV_INDEX_WIDTH-1:0]   csr_index;
   sm3_cmd_type                 cmd;
   sm3_cv_type                  digest;

   // IV register file: each register sits at byte address 4*i.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CSR_ADDR_WIDTH-1:2];
   assign prdata    = iv_ff[csr_index];

   always_comb begin
      iv_in = iv_ff;
      if (csr_write) begin
         iv_in[csr_index] = pwdata;
      end
   end

   // IV writes only take effect at the next start flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= IV_RESET;
      end else begin
         iv_ff <= iv_in;
      end
   end

   // Sequence word gathering, the 64 rounds and the result transaction.
   sm3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_start (req_chan.start_message),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Hold the message window, working state, chaining value and output register.
   sm3_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .message_word (req_chan.message_word),
      .iv           (iv_ff),
      .digest       (digest)
   );

   // Word A sits in the top half of the first output field.
   assign rsp_chan.digest_bits_255_192 = {digest[0], digest[1]};
   assign rsp_chan.digest_bits_191_128 = {digest[2], digest[3]};
   assign rsp_chan.digest_bits_127_64  = {digest[4], digest[5]};
   assign rsp_chan.digest_bits_63_0    = {digest[6], digest[7]};

`ifndef ASSERT_OFF
   // No new word enters while the rounds run.
   a_no_accept_in_rounds: assert property (
      @(posedge clock) disable iff (reset) cmd.do_round |-> !req_chan.ready
   ) else $error("word accepted during compression rounds");

   // Fold only into a free output register.
   a_finish_slot_free: assert property (
      @(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_chan.valid || rsp_chan.ready)
   ) else $error("result overwritten before its transaction completed");

   // A fold always presents a result on the next cycle.
   a_finish_shows_result: assert property (
      @(posedge clock) disable iff (reset) cmd.finish |=> rsp_chan.valid
   ) else $error("folded block produced no result");

   // Word loading and rounds never share a cycle.
   a_load_excl_round: assert property (
      @(posedge clock) disable iff (reset) !(cmd.load_word && cmd.do_round)
   ) else $error("word load collided with a round");
`endif

endmodule
